// File: src/hct_pkg.sv
// Shared types, constants and rounding helpers for the hex cell tracker.
// Used by every module of the block; depends on nothing.
package hct_pkg;

    localparam int QDEPTH = 2;

    localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [1:0] CFG_INV_SIZE = 2'd2;

    localparam logic [31:0] INV_SIZE_RESET = 32'd42949673;

    // Pointy-top axial constants in Q0.20.
    localparam logic signed [20:0] K_SQRT3_3   = 21'sd605396;
    localparam logic signed [20:0] K_THIRD     = 21'sd349525;
    localparam logic signed [20:0] K_TWO_THIRD = 21'sd699051;

    localparam logic signed [63:0] ROUND_HALF = 64'sh0000_0008_0000_0000;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
    } hct_item_t;

    typedef struct packed {
        logic [1:0] count;
        logic       full;
        logic       empty;
    } hct_qstat_t;

    typedef struct packed {
        logic busy;
        logic commit;
    } hct_bstat_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SY,
        BK_FQ,
        BK_FR,
        BK_RND,
        BK_OUT
    } hct_bstate_t;

    typedef enum logic [1:0] {
        CM_SQRT3_X,
        CM_THIRD_Y,
        CM_TWO_THIRD_Y
    } hct_cmsel_t;

    typedef struct packed {
        logic signed [27:0] rnd;
        logic [35:0]        err;
    } hct_rnd_t;

    // Round half up from Q.36 and give the exact magnitude of the rounding error.
    function automatic hct_rnd_t round_fix(input logic signed [63:0] v);
        logic signed [63:0] t;
        logic signed [36:0] e;
        logic signed [36:0] ne;
        hct_rnd_t           r;
        t     = v + ROUND_HALF;
        r.rnd = t[63:36];
        e     = $signed({2'b01, 35'd0}) - $signed({1'b0, t[35:0]});
        ne    = -e;
        r.err = e[36] ? ne[35:0] : e[35:0];
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [28:0] v);
        logic signed [15:0] r;
        if (v > 29'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -29'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// File: src/hct_queue.sv
// Two-entry queue of origin-relative positions between front and back end.
// Depends on hct_pkg.
module hct_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hct_pkg::hct_item_t push_item,
    input  logic              pop,
    output hct_pkg::hct_item_t head,
    output hct_pkg::hct_qstat_t stat
);

    hct_pkg::hct_item_t mem_reg [hct_pkg::QDEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.count = cnt_reg;
    assign stat.full  = (cnt_reg == 2'(hct_pkg::QDEPTH));
    assign stat.empty = (cnt_reg == 2'd0);

endmodule

// File: src/hct_front.sv
// Front end: takes positions and forms the full-width offset from the grid origin.
// Depends on hct_pkg; feeds hct_queue.
module hct_front (
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        pos_x,
    input  logic [31:0]        pos_y,
    input  logic [31:0]        origin_x,
    input  logic [31:0]        origin_y,
    input  hct_pkg::hct_qstat_t qstat,
    output logic               push,
    output hct_pkg::hct_item_t  push_item
);

    assign in_stall     = qstat.full;
    assign push         = in_valid && !qstat.full;
    assign push_item.dx = $signed({pos_x[31], pos_x}) - $signed({origin_x[31], origin_x});
    assign push_item.dy = $signed({pos_y[31], pos_y}) - $signed({origin_y[31], origin_y});

endmodule

// File: src/hct_back.sv
// Back end: scales by the inverse hex size, maps to axial form, cube-rounds,
// saturates and tracks the last cell. Depends on hct_pkg; reads hct_queue.
module hct_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [31:0]        inv_hex_size,
    input  hct_pkg::hct_item_t  head,
    input  hct_pkg::hct_qstat_t qstat,
    output logic               pop,
    input  logic               out_stall,
    output logic               out_valid,
    output logic [15:0]        hex_q,
    output logic [15:0]        hex_r,
    output logic               cell_changed,
    output hct_pkg::hct_bstat_t stat
);

    hct_pkg::hct_bstate_t state_reg;
    hct_pkg::hct_bstate_t state_next;

    logic signed [32:0] dy_reg;
    logic signed [40:0] ux_reg;
    logic signed [40:0] uy_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] fr_reg;
    logic signed [27:0] rx_reg;
    logic signed [27:0] ry_reg;
    logic signed [27:0] rz_reg;
    logic [35:0]        ex_reg;
    logic [35:0]        ey_reg;
    logic [35:0]        ez_reg;
    logic signed [15:0] last_q_reg;
    logic signed [15:0] last_r_reg;
    logic               have_last_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [15:0]        hex_q_reg;
    logic [15:0]        hex_r_reg;
    logic               changed_reg;

    logic signed [32:0] s_in;
    logic signed [32:0] s_mag33;
    logic [31:0]        s_mag;
    logic [63:0]        s_prod;
    logic [63:0]        s_adj;
    logic signed [40:0] s_res;

    hct_pkg::hct_cmsel_t cm_sel;
    logic signed [20:0]  cm_k;
    logic signed [40:0]  cm_u;
    logic signed [63:0]  cm_prod;

    logic signed [63:0] fs;
    hct_pkg::hct_rnd_t  rnd_x;
    hct_pkg::hct_rnd_t  rnd_y;
    hct_pkg::hct_rnd_t  rnd_z;

    logic signed [28:0] rx_w;
    logic signed [28:0] ry_w;
    logic signed [28:0] rz_w;
    logic signed [28:0] q_w;
    logic signed [28:0] r_w;
    logic signed [15:0] q_sat;
    logic signed [15:0] r_sat;
    logic               changed;
    logic               commit;

    // Shared scale unit: floor(d * inv / 2^24) on sign and magnitude.
    always_comb
    begin
        s_in    = (state_reg == hct_pkg::BK_IDLE) ? head.dx : dy_reg;
        s_mag33 = s_in[32] ? -s_in : s_in;
        s_mag   = s_mag33[31:0];
        s_prod  = s_mag * inv_hex_size;
        s_adj   = s_in[32] ? s_prod + 64'h0000_0000_00FF_FFFF : s_prod;
        s_res   = s_in[32] ? -$signed({1'b0, s_adj[63:24]}) : $signed({1'b0, s_adj[63:24]});
    end

    // Shared constant multiplier.
    always_comb
    begin
        case (state_reg)
            hct_pkg::BK_FQ: cm_sel = hct_pkg::CM_THIRD_Y;
            hct_pkg::BK_FR: cm_sel = hct_pkg::CM_TWO_THIRD_Y;
            default:        cm_sel = hct_pkg::CM_SQRT3_X;
        endcase
        case (cm_sel)
            hct_pkg::CM_THIRD_Y:
            begin
                cm_k = hct_pkg::K_THIRD;
                cm_u = uy_reg;
            end
            hct_pkg::CM_TWO_THIRD_Y:
            begin
                cm_k = hct_pkg::K_TWO_THIRD;
                cm_u = uy_reg;
            end
            default:
            begin
                cm_k = hct_pkg::K_SQRT3_3;
                cm_u = ux_reg;
            end
        endcase
        cm_prod = cm_k * cm_u;
    end

    always_comb
    begin
        fs    = -acc_reg - fr_reg;
        rnd_x = hct_pkg::round_fix(acc_reg);
        rnd_y = hct_pkg::round_fix(fs);
        rnd_z = hct_pkg::round_fix(fr_reg);
    end

    // Rebuild the axis with the largest rounding error from the other two.
    always_comb
    begin
        rx_w = 29'(rx_reg);
        ry_w = 29'(ry_reg);
        rz_w = 29'(rz_reg);
        if (ex_reg > ey_reg && ex_reg > ez_reg) begin
            q_w = -ry_w - rz_w;
            r_w = rz_w;
        end else if (ey_reg > ez_reg) begin
            q_w = rx_w;
            r_w = rz_w;
        end else begin
            q_w = rx_w;
            r_w = -rx_w - ry_w;
        end
        q_sat   = hct_pkg::sat16(q_w);
        r_sat   = hct_pkg::sat16(r_w);
        changed = !have_last_reg || (q_sat != last_q_reg) || (r_sat != last_r_reg);
    end

    always_comb
    begin
        pop        = 1'b0;
        commit     = 1'b0;
        state_next = state_reg;
        case (state_reg)
            hct_pkg::BK_IDLE:
            begin
                if (!qstat.empty) begin
                    pop        = 1'b1;
                    state_next = hct_pkg::BK_SY;
                end
            end
            hct_pkg::BK_SY:  state_next = hct_pkg::BK_FQ;
            hct_pkg::BK_FQ:  state_next = hct_pkg::BK_FR;
            hct_pkg::BK_FR:  state_next = hct_pkg::BK_RND;
            hct_pkg::BK_RND: state_next = hct_pkg::BK_OUT;
            hct_pkg::BK_OUT:
            begin
                if (!out_valid_reg || !out_stall) begin
                    commit     = 1'b1;
                    state_next = hct_pkg::BK_IDLE;
                end
            end
            default: state_next = hct_pkg::BK_IDLE;
        endcase
        out_valid_next = commit || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= hct_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            have_last_reg <= 1'b0;
            last_q_reg    <= 16'sd0;
            last_r_reg    <= 16'sd0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit) begin
                have_last_reg <= 1'b1;
                last_q_reg    <= q_sat;
                last_r_reg    <= r_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            hct_pkg::BK_IDLE:
            begin
                ux_reg <= s_res;
                dy_reg <= head.dy;
            end
            hct_pkg::BK_SY:
            begin
                uy_reg  <= s_res;
                acc_reg <= cm_prod;
            end
            hct_pkg::BK_FQ:  acc_reg <= acc_reg - cm_prod;
            hct_pkg::BK_FR:  fr_reg <= cm_prod;
            hct_pkg::BK_RND:
            begin
                rx_reg <= rnd_x.rnd;
                ry_reg <= rnd_y.rnd;
                rz_reg <= rnd_z.rnd;
                ex_reg <= rnd_x.err;
                ey_reg <= rnd_y.err;
                ez_reg <= rnd_z.err;
            end
            default:
            begin
                if (commit) begin
                    hex_q_reg   <= q_sat;
                    hex_r_reg   <= r_sat;
                    changed_reg <= changed;
                end
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign hex_q        = hex_q_reg;
    assign hex_r        = hex_r_reg;
    assign cell_changed = changed_reg;
    assign stat.busy    = (state_reg != hct_pkg::BK_IDLE);
    assign stat.commit  = commit;

endmodule

// File: src/position_to_hex_cell_tracker_unit.sv
// Top level of the hex cell tracker: configuration registers, front end, queue, back end.
// Depends on hct_pkg, hct_front, hct_queue and hct_back.

// Maps Q23.8 positions onto a pointy-top axial hex grid and reports hex_q, hex_r
// (saturated to 16 bits) and cell_changed, one result beat per position beat.
// The front end subtracts the origin and places the offset in a two-entry queue,
// so up to two positions are taken while earlier work is in progress. The back end
// handles one position at a time, through SY, FQ, FR, RND and OUT to the output register:
// one 32 by 32 multiplier scales x and y, and one shared constant multiplier forms
// the three axial products in turn. OUT waits while an earlier result is still stalled.
// Write configuration only while the block is idle.
module position_to_hex_cell_tracker_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] hex_q,
    output logic [15:0] hex_r,
    output logic        cell_changed
);

    logic [31:0] origin_x_reg;
    logic [31:0] origin_y_reg;
    logic [31:0] inv_size_reg;

    logic                push;
    logic                pop;
    hct_pkg::hct_item_t  push_item;
    hct_pkg::hct_item_t  head;
    hct_pkg::hct_qstat_t qstat;
    hct_pkg::hct_bstat_t bstat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            origin_x_reg <= 32'd0;
            origin_y_reg <= 32'd0;
            inv_size_reg <= hct_pkg::INV_SIZE_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                hct_pkg::CFG_ORIGIN_X: origin_x_reg <= cfg_data;
                hct_pkg::CFG_ORIGIN_Y: origin_y_reg <= cfg_data;
                hct_pkg::CFG_INV_SIZE: inv_size_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    hct_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .origin_x  (origin_x_reg),
        .origin_y  (origin_y_reg),
        .qstat     (qstat),
        .push      (push),
        .push_item (push_item)
    );

    hct_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .stat      (qstat)
    );

    hct_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .inv_hex_size (inv_size_reg),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .hex_q        (hex_q),
        .hex_r        (hex_r),
        .cell_changed (cell_changed),
        .stat         (bstat)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.count <= 2'(hct_pkg::QDEPTH))
        else $error("queue count exceeds its depth");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> qstat.count == 2'(hct_pkg::QDEPTH))
        else $error("input stalled while the queue has room");

    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(bstat.commit))
        else $error("result appeared without a back-end commit");

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !bstat.busy && !qstat.empty)
        else $error("queue popped while the back end is busy or the queue is empty");

endmodule

// File: tb/position_to_hex_cell_tracker_unit_tb.sv
// Testbench for position_to_hex_cell_tracker_unit: a self-checking run that maps
// positions to axial hex cells and checks every result beat against its own prediction.
// Depends on hct_pkg for the register indexes and on the unit itself; nothing else.
module position_to_hex_cell_tracker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CYCLE_LIMIT      = 1000000;
    localparam int     SETTLE_CYCLES    = 30;
    localparam int     PHASE_COUNT      = 10;
    localparam int     ITEMS_PER_PHASE  = 125;
    localparam longint ROOT3_OVER_3_Q20 = 605396;
    localparam longint ONE_THIRD_Q20    = 349525;
    localparam longint TWO_THIRDS_Q20   = 699051;
    localparam longint HALF_Q36         = 64'sh0000_0008_0000_0000;
    localparam logic [31:0] DEFAULT_INV = 32'd42949673;
    localparam logic [31:0] S32_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN     = 32'h8000_0000;

    typedef struct packed {
        logic [15:0] q;
        logic [15:0] r;
        logic        changed;
    } cell_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] hex_q;
    logic [15:0] hex_r;
    logic        cell_changed;

    logic [31:0]  grid_origin_x;
    logic [31:0]  grid_origin_y;
    logic [31:0]  grid_inv_size;
    logic [15:0]  prev_q;
    logic [15:0]  prev_r;
    logic         prev_valid;
    logic [31:0]  walk_x;
    logic [31:0]  walk_y;
    cell_result_t pending_cells[$];
    bit           sender_gaps;
    int           cycle_count;
    int           mismatch_count;
    int           positions_sent;
    int           results_checked;
    int           changes_predicted;
    int           settings_used;

    position_to_hex_cell_tracker_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hex_q        (hex_q),
        .hex_r        (hex_r),
        .cell_changed (cell_changed)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint scale_to_hex_units(input longint offset);
        longint unsigned mag;
        longint unsigned prod;
        mag  = (offset < 0) ? -offset : offset;
        prod = mag * {32'd0, grid_inv_size};
        if (offset >= 0)
        begin
            return longint'(prod >> 24);
        end
        return -longint'((prod + 64'h0000_0000_00FF_FFFF) >> 24);
    endfunction

    function automatic longint round_half_up(input longint v);
        return (v + HALF_Q36) >>> 36;
    endfunction

    function automatic longint rounding_error(input longint rounded, input longint v);
        longint e;
        e = (rounded <<< 36) - v;
        return (e < 0) ? -e : e;
    endfunction

    function automatic logic [15:0] clamp16(input longint v);
        if (v > 32767)
        begin
            return 16'h7FFF;
        end
        if (v < -32768)
        begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    function automatic cell_result_t locate_hex(input logic [31:0] px, input logic [31:0] py);
        longint       dx;
        longint       dy;
        longint       ux;
        longint       uy;
        longint       fq;
        longint       fr;
        longint       fs;
        longint       cq;
        longint       cr;
        longint       cs;
        longint       eq;
        longint       er;
        longint       es;
        cell_result_t res;
        dx = longint'(signed'(px)) - longint'(signed'(grid_origin_x));
        dy = longint'(signed'(py)) - longint'(signed'(grid_origin_y));
        ux = scale_to_hex_units(dx);
        uy = scale_to_hex_units(dy);
        fq = ROOT3_OVER_3_Q20 * ux - ONE_THIRD_Q20 * uy;
        fr = TWO_THIRDS_Q20 * uy;
        fs = -fq - fr;
        cq = round_half_up(fq);
        cs = round_half_up(fs);
        cr = round_half_up(fr);
        eq = rounding_error(cq, fq);
        es = rounding_error(cs, fs);
        er = rounding_error(cr, fr);
        if (eq > es && eq > er)
        begin
            cq = -cs - cr;
        end
        else if (es > er)
        begin
            cs = -cq - cr;
        end
        else
        begin
            cr = -cq - cs;
        end
        res.q       = clamp16(cq);
        res.r       = clamp16(cr);
        res.changed = !prev_valid || res.q != prev_q || res.r != prev_r;
        return res;
    endfunction

    task automatic track_position(input logic [31:0] px, input logic [31:0] py);
        cell_result_t res;
        res        = locate_hex(px, py);
        prev_q     = res.q;
        prev_r     = res.r;
        prev_valid = 1'b1;
        pending_cells.push_back(res);
        if (res.changed)
        begin
            changes_predicted++;
        end
    endtask

    function automatic int pick_gap();
        int roll;
        if (!sender_gaps)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 88)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    task automatic send_position(input logic [31:0] px, input logic [31:0] py);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        pos_x    <= px;
        pos_y    <= py;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        track_position(px, py);
        positions_sent++;
        walk_x = px;
        walk_y = py;
        gap    = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_for_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_cells.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        wait_for_idle();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            hct_pkg::CFG_ORIGIN_X: grid_origin_x = value;
            hct_pkg::CFG_ORIGIN_Y: grid_origin_y = value;
            hct_pkg::CFG_INV_SIZE: grid_inv_size = value;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [31:0] ox, input logic [31:0] oy,
                                 input logic [31:0] inv);
        write_register(hct_pkg::CFG_ORIGIN_X, ox);
        write_register(hct_pkg::CFG_ORIGIN_Y, oy);
        write_register(hct_pkg::CFG_INV_SIZE, inv);
        settings_used++;
    endtask

    function automatic longint hex_span_raw();
        longint span;
        if (grid_inv_size == 0)
        begin
            return 64'd2147483647;
        end
        span = (64'sd1 <<< 40) / longint'({32'd0, grid_inv_size});
        return (span > 64'd2147483647) ? 64'd2147483647 : span;
    endfunction

    function automatic logic [31:0] random_offset(input longint limit);
        longint unsigned pick;
        pick = {$urandom, $urandom} % longint'(2 * limit + 1);
        return 32'(longint'(pick) - limit);
    endfunction

    task automatic send_random_position();
        int     roll;
        longint span;
        longint step;
        roll = $urandom_range(0, 99);
        span = hex_span_raw();
        if (roll < 50)
        begin
            step = span / 4;
            if (step > 64'd1048576)
            begin
                step = 64'd1048576;
            end
            send_position(walk_x + random_offset(step), walk_y + random_offset(step));
        end
        else if (roll < 80)
        begin
            span = span * 12;
            if (span > 64'd2147483647)
            begin
                span = 64'd2147483647;
            end
            send_position(grid_origin_x + random_offset(span),
                          grid_origin_y + random_offset(span));
        end
        else
        begin
            send_position($urandom, $urandom);
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        cell_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (pending_cells.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat q=%0d r=%0d changed=%0b",
                    $signed(hex_q), $signed(hex_r), cell_changed));
            end
            else
            begin
                want = pending_cells.pop_front();
                if (hex_q !== want.q || hex_r !== want.r || cell_changed !== want.changed)
                begin
                    report_mismatch($sformatf(
                        "expected q=%0d r=%0d changed=%0b, got q=%0d r=%0d changed=%0b",
                        $signed(want.q), $signed(want.r), want.changed,
                        $signed(hex_q), $signed(hex_r), cell_changed));
                end
            end
        end
    end

    initial
    begin : stall_driver
        int roll;
        int hold;
        out_stall = 1'b0;
        forever
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
            begin
                hold = $urandom_range(1, 20);
                @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (roll < 85)
            begin
                hold = $urandom_range(1, 3);
                @(negedge clk);
                out_stall <= 1'b1;
            end
            else if (roll < 95)
            begin
                hold = $urandom_range(10, 40);
                @(negedge clk);
                out_stall <= 1'b1;
            end
            else
            begin
                hold = $urandom_range(100, 300);
                @(negedge clk);
                out_stall <= 1'b0;
            end
            repeat (hold - 1) @(negedge clk);
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run timed out with %0d results outstanding", pending_cells.size());
        $display("status: fail");
        $finish;
    end

    // The first beat always flags a change; repeating a position must not.
    task automatic test_first_and_repeat();
        send_position(32'd0, 32'd0);
        send_position(32'd0, 32'd0);
        send_position(32'd25600, 32'd0);
        send_position(32'd0, 32'd25600);
        send_position(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // With y on the origin row the X and Y rounding errors are equal.
    task automatic test_axis_ties();
        send_position(32'd12800, 32'd0);
        send_position(-32'sd3000, 32'd0);
        send_position(32'd44345, 32'd0);
    endtask

    // Offsets near 2^32 with the largest reciprocal drive Q and R into saturation; the smallest keeps them near zero.
    task automatic test_large_offsets();
        apply_setting(S32_MIN, S32_MAX, 32'hFFFF_FFFF);
        send_position(S32_MAX, S32_MIN);
        send_position(S32_MIN, S32_MAX);
        apply_setting(S32_MAX, S32_MIN, 32'hFFFF_FFFF);
        send_position(S32_MIN, S32_MAX);
        send_position(S32_MAX, S32_MIN);
        apply_setting(S32_MIN, S32_MAX, 32'd1);
        send_position(S32_MAX, S32_MIN);
        send_position(S32_MIN, S32_MAX);
    endtask

    // A zero reciprocal collapses every position onto hex 0,0.
    task automatic test_zero_reciprocal();
        apply_setting(32'h1234_5678, 32'hFEDC_BA98, 32'd0);
        send_position(S32_MAX, S32_MAX);
        send_position(S32_MIN, 32'd0);
        send_position(32'hA5A5_5A5A, 32'h5A5A_A5A5);
    endtask

    task automatic test_random_phases();
        logic [31:0] inv;
        logic [31:0] ox;
        logic [31:0] oy;
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0:       inv = DEFAULT_INV;
                1:       inv = 32'hFFFF_FFFF;
                2:       inv = 32'd1;
                3:       inv = $urandom_range(32'h0010_0000, 32'h1000_0000);
                4:       inv = $urandom_range(32'h0100_0000, 32'h4000_0000);
                default: inv = $urandom_range(32'hFFFF_FFFF, 32'd1);
            endcase
            if (ph % 2 == 1)
            begin
                ox = $urandom;
                oy = $urandom;
            end
            else
            begin
                ox = random_offset(64'd65536);
                oy = random_offset(64'd65536);
            end
            apply_setting(ox, oy, inv);
            sender_gaps = (ph != 4 && ph != 7);
            walk_x      = ox;
            walk_y      = oy;
            repeat (ITEMS_PER_PHASE) send_random_position();
        end
        sender_gaps = 1'b1;
    endtask

    initial
    begin : sequencer
        rst_n             = 1'b0;
        cfg_write         = 1'b0;
        cfg_index         = hct_pkg::CFG_ORIGIN_X;
        cfg_data          = 32'd0;
        in_valid          = 1'b0;
        pos_x             = 32'd0;
        pos_y             = 32'd0;
        grid_origin_x     = 32'd0;
        grid_origin_y     = 32'd0;
        grid_inv_size     = DEFAULT_INV;
        prev_q            = 16'd0;
        prev_r            = 16'd0;
        prev_valid        = 1'b0;
        walk_x            = 32'd0;
        walk_y            = 32'd0;
        sender_gaps       = 1'b1;
        mismatch_count    = 0;
        positions_sent    = 0;
        results_checked   = 0;
        changes_predicted = 0;
        settings_used     = 1;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_first_and_repeat();
        test_axis_ties();
        test_large_offsets();
        test_zero_reciprocal();
        test_random_phases();

        wait_for_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("sent %0d positions over %0d register settings, %0d predicted cell changes",
            positions_sent, settings_used, changes_predicted);
        $display("checked %0d result beats, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0 && pending_cells.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
